### hw/rtl/mqmb_pkg.sv
`default_nettype none
package mqmb_pkg;

  localparam int NUM_QUEUES    = 16;
  localparam int MAX_DEPTH     = 16;
  localparam int MAX_MSG_BYTES = 8;

  localparam int REQ_W  = 2;
  localparam int Q_W    = 4;
  localparam int NB_W   = 4;
  localparam int DEP_W  = 5;
  localparam int MSG_W  = 64;
  localparam int ST_W   = 3;
  localparam int FILL_W = 5;
  localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ADDR_W = Q_W + PTR_W;
  localparam int STORE_DEPTH = NUM_QUEUES * MAX_DEPTH;
  localparam int MSG_BYTES = MSG_W / 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_SEND   = 2'd1,
    REQ_RECV   = 2'd2
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_SIZE    = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_NOSPACE = 3'd4,
    ST_NOTOPEN = 3'd5
  } status_t;

  function automatic logic [MSG_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
    logic [MSG_W-1:0] m;
    m = '0;
    for (int i = 0; i < MSG_BYTES; i++) begin
      m[i*8 +: 8] = (NB_W'(i) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mqmb_ram.sv
`default_nettype none
module mqmb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### hw/rtl/multi_queue_message_mailbox.sv
`default_nettype none
// Mailbox with a bank of ring-buffer message queues. busy stays low: a request
// beat is taken on every cycle that start is high, and its result is shown
// for exactly one cycle with out_valid high. The receiver cannot stall, so
// capture out_* whenever out_valid is set. Throughput is one request per cycle.
// A request passes the input register, then the single-pass queue update,
// whose result is registered along with the registered message store read.
module multi_queue_message_mailbox (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mqmb_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [mqmb_pkg::Q_W-1:0]      in_queue_sel,
  input  wire logic [mqmb_pkg::NB_W-1:0]     in_byte_count,
  input  wire logic [mqmb_pkg::DEP_W-1:0]    in_depth_req,
  input  wire logic [mqmb_pkg::MSG_W-1:0]    in_msg_in,
  input  wire logic                          in_may_wait,
  output logic                               out_valid,
  output logic      [mqmb_pkg::ST_W-1:0]     out_status,
  output logic      [mqmb_pkg::Q_W-1:0]      out_new_queue,
  output logic      [mqmb_pkg::MSG_W-1:0]    out_msg_out,
  output logic      [mqmb_pkg::FILL_W-1:0]   out_fill_after
);
  import mqmb_pkg::*;

  logic               va_r;
  req_t               req_r;
  logic [Q_W-1:0]     q_r;
  logic [NB_W-1:0]    nb_r;
  logic [DEP_W-1:0]   dreq_r;
  logic [MSG_W-1:0]   msg_r;
  logic               wait_r;

  logic [NUM_QUEUES-1:0] used_r;
  logic [PTR_W-1:0]      rd_ptr_r [NUM_QUEUES];
  logic [PTR_W-1:0]      wr_ptr_r [NUM_QUEUES];
  logic [FILL_W-1:0]     fill_r   [NUM_QUEUES];
  logic [NB_W-1:0]       size_r   [NUM_QUEUES];
  logic [DEP_W-1:0]      lim_r    [NUM_QUEUES];

  logic               vb_r;
  status_t            st_r;
  logic [Q_W-1:0]     newq_r;
  logic [FILL_W-1:0]  fill_out_r;
  logic [MSG_W-1:0]   mask_r;

  logic               open_q;
  logic [FILL_W-1:0]  cur_fill;
  logic [DEP_W-1:0]   cur_lim;
  logic [PTR_W-1:0]   cur_rd;
  logic [PTR_W-1:0]   cur_wr;
  logic               any_free;
  logic [Q_W-1:0]     found;
  logic               create_ok;
  logic               send_ok;
  logic               recv_ok;
  status_t            st_nxt;
  logic [Q_W-1:0]     newq_nxt;
  logic [FILL_W-1:0]  fill_nxt;
  logic [MSG_W-1:0]   mask_nxt;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [DEP_W-1:0]   rd_inc;
  logic [DEP_W-1:0]   wr_inc;
  logic [MSG_W-1:0]   ram_rdata;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r  <= req_t'(in_req_type);
      q_r    <= in_queue_sel;
      nb_r   <= in_byte_count;
      dreq_r <= in_depth_req;
      msg_r  <= in_msg_in;
      wait_r <= in_may_wait;
    end
  end

  always_comb begin
    any_free = 1'b0;
    found    = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        any_free = 1'b1;
        found    = Q_W'(i);
      end
    end
  end

  always_comb begin
    open_q   = used_r[q_r];
    cur_fill = fill_r[q_r];
    cur_lim  = lim_r[q_r];
    cur_rd   = rd_ptr_r[q_r];
    cur_wr   = wr_ptr_r[q_r];

    rd_inc     = DEP_W'(cur_rd) + DEP_W'(1);
    wr_inc     = DEP_W'(cur_wr) + DEP_W'(1);
    rd_ptr_nxt = (rd_inc >= cur_lim) ? '0 : rd_inc[PTR_W-1:0];
    wr_ptr_nxt = (wr_inc >= cur_lim) ? '0 : wr_inc[PTR_W-1:0];

    create_ok = 1'b0;
    send_ok   = 1'b0;
    recv_ok   = 1'b0;
    st_nxt    = ST_OK;
    newq_nxt  = '0;
    fill_nxt  = '0;

    unique case (req_r)
      REQ_CREATE: begin
        if (!any_free || dreq_r == '0 || dreq_r > DEP_W'(MAX_DEPTH) ||
            nb_r > NB_W'(MAX_MSG_BYTES)) begin
          st_nxt = ST_NOSPACE;
        end else begin
          create_ok = 1'b1;
          newq_nxt  = found;
        end
      end
      REQ_SEND, REQ_RECV: begin
        if (!open_q) begin
          st_nxt = ST_NOTOPEN;
        end else if (nb_r != size_r[q_r]) begin
          st_nxt   = ST_SIZE;
          fill_nxt = cur_fill;
        end else if (req_r == REQ_SEND) begin
          if (cur_fill >= cur_lim) begin
            st_nxt   = wait_r ? ST_BLOCKED : ST_TIMEOUT;
            fill_nxt = cur_fill;
          end else begin
            send_ok  = 1'b1;
            fill_nxt = cur_fill + FILL_W'(1);
          end
        end else begin
          if (cur_fill == '0) begin
            st_nxt   = wait_r ? ST_BLOCKED : ST_TIMEOUT;
            fill_nxt = cur_fill;
          end else begin
            recv_ok  = 1'b1;
            fill_nxt = cur_fill - FILL_W'(1);
          end
        end
      end
      default: begin
        fill_nxt = open_q ? cur_fill : '0;
      end
    endcase

    create_ok = create_ok & va_r;
    send_ok   = send_ok & va_r;
    recv_ok   = recv_ok & va_r;
    mask_nxt  = recv_ok ? byte_mask(nb_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        fill_r[i]   <= '0;
        size_r[i]   <= '0;
        lim_r[i]    <= '0;
      end
    end else begin
      if (create_ok) begin
        used_r[found]   <= 1'b1;
        size_r[found]   <= nb_r;
        lim_r[found]    <= dreq_r;
        rd_ptr_r[found] <= '0;
        wr_ptr_r[found] <= '0;
        fill_r[found]   <= '0;
      end
      if (send_ok) begin
        wr_ptr_r[q_r] <= wr_ptr_nxt;
        fill_r[q_r]   <= fill_nxt;
      end
      if (recv_ok) begin
        rd_ptr_r[q_r] <= rd_ptr_nxt;
        fill_r[q_r]   <= fill_nxt;
      end
    end
  end

  mqmb_ram #(
    .WIDTH (MSG_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (send_ok),
    .waddr ({q_r, cur_wr}),
    .wdata (msg_r & byte_mask(nb_r)),
    .re    (recv_ok),
    .raddr ({q_r, cur_rd}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (va_r) begin
      st_r       <= st_nxt;
      newq_r     <= newq_nxt;
      fill_out_r <= fill_nxt;
      mask_r     <= mask_nxt;
    end
  end

  assign out_valid      = vb_r;
  assign out_status     = st_r;
  assign out_new_queue  = newq_r;
  assign out_fill_after = fill_out_r;
  assign out_msg_out    = ram_rdata & mask_r;

endmodule
`default_nettype wire

### verif/mailbox_tracker_pkg.sv
package mailbox_tracker_pkg;
  import mqmb_pkg::*;

  typedef struct {
    status_t             status;
    logic [Q_W-1:0]      new_queue;
    logic [MSG_W-1:0]    msg;
    logic [FILL_W-1:0]   fill;
  } mbx_reply_t;

  class mailbox_tracker;
    bit                  q_open      [NUM_QUEUES];
    logic [PTR_W-1:0]    rd_ptr      [NUM_QUEUES];
    logic [PTR_W-1:0]    wr_ptr      [NUM_QUEUES];
    logic [FILL_W-1:0]   q_fill      [NUM_QUEUES];
    logic [NB_W-1:0]     q_msg_bytes [NUM_QUEUES];
    logic [DEP_W-1:0]    q_depth     [NUM_QUEUES];
    logic [MSG_W-1:0]    slot_data   [STORE_DEPTH];
    mbx_reply_t          replies_due [$];
    int                  fails;

    function new();
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_open[i]      = 1'b0;
        rd_ptr[i]      = '0;
        wr_ptr[i]      = '0;
        q_fill[i]      = '0;
        q_msg_bytes[i] = '0;
        q_depth[i]     = '0;
      end
      fails = 0;
    endfunction

    function logic [MSG_W-1:0] keep_bytes(logic [NB_W-1:0] nb);
      if (nb >= MSG_BYTES) return '1;
      return (MSG_W'(1) << (8 * nb)) - MSG_W'(1);
    endfunction

    function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p, logic [DEP_W-1:0] lim);
      return (int'(p) + 1 >= int'(lim)) ? '0 : p + 1'b1;
    endfunction

    function void log_request(logic [REQ_W-1:0] rq, logic [Q_W-1:0] qs,
                              logic [NB_W-1:0] nb, logic [DEP_W-1:0] dr,
                              logic [MSG_W-1:0] pl, logic mw);
      mbx_reply_t r;
      int         slot;
      r.status    = ST_OK;
      r.new_queue = '0;
      r.msg       = '0;
      r.fill      = '0;
      slot        = NUM_QUEUES;
      case (rq)
        REQ_CREATE: begin
          for (int i = NUM_QUEUES - 1; i >= 0; i--) if (!q_open[i]) slot = i;
          if (slot == NUM_QUEUES || dr == 0 || dr > MAX_DEPTH || nb > MAX_MSG_BYTES) begin
            r.status = ST_NOSPACE;
          end else begin
            q_open[slot]      = 1'b1;
            q_msg_bytes[slot] = nb;
            q_depth[slot]     = dr;
            rd_ptr[slot]      = '0;
            wr_ptr[slot]      = '0;
            q_fill[slot]      = '0;
            r.new_queue       = Q_W'(slot);
          end
        end
        REQ_SEND, REQ_RECV: begin
          if (!q_open[qs]) begin
            r.status = ST_NOTOPEN;
          end else if (nb != q_msg_bytes[qs]) begin
            r.status = ST_SIZE;
            r.fill   = q_fill[qs];
          end else if (rq == REQ_SEND) begin
            if (q_fill[qs] >= q_depth[qs]) begin
              r.status = mw ? ST_BLOCKED : ST_TIMEOUT;
            end else begin
              slot_data[{qs, wr_ptr[qs]}] = pl & keep_bytes(nb);
              wr_ptr[qs] = step_ptr(wr_ptr[qs], q_depth[qs]);
              q_fill[qs] = q_fill[qs] + 1'b1;
            end
            r.fill = q_fill[qs];
          end else begin
            if (q_fill[qs] == 0) begin
              r.status = mw ? ST_BLOCKED : ST_TIMEOUT;
            end else begin
              r.msg      = slot_data[{qs, rd_ptr[qs]}] & keep_bytes(nb);
              rd_ptr[qs] = step_ptr(rd_ptr[qs], q_depth[qs]);
              q_fill[qs] = q_fill[qs] - 1'b1;
            end
            r.fill = q_fill[qs];
          end
        end
        default: begin
          if (q_open[qs]) r.fill = q_fill[qs];
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void match_reply(logic [ST_W-1:0] st, logic [Q_W-1:0] nq,
                              logic [MSG_W-1:0] msg, logic [FILL_W-1:0] fill);
      mbx_reply_t e;
      if (replies_due.size() == 0) begin
        if (fails < 10)
          $display("reply with none pending: status %0d queue %0d msg %h fill %0d",
                   st, nq, msg, fill);
        fails++;
        return;
      end
      e = replies_due.pop_front();
      if (e.status !== st || e.new_queue !== nq || e.msg !== msg || e.fill !== fill) begin
        if (fails < 10) begin
          $display("mismatch: expected status %0d queue %0d msg %h fill %0d",
                   e.status, e.new_queue, e.msg, e.fill);
          $display("          actual   status %0d queue %0d msg %h fill %0d",
                   st, nq, msg, fill);
        end
        fails++;
      end
    endfunction
  endclass

endpackage

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mqmb_pkg::*;
  import mailbox_tracker_pkg::*;

  localparam logic [REQ_W-1:0] REQ_T3 = REQ_W'(3);

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic [REQ_W-1:0]    in_req_type    = '0;
  logic [Q_W-1:0]      in_queue_sel   = '0;
  logic [NB_W-1:0]     in_byte_count  = '0;
  logic [DEP_W-1:0]    in_depth_req   = '0;
  logic [MSG_W-1:0]    in_msg_in      = '0;
  logic                in_may_wait    = 1'b0;
  logic                busy;
  logic                out_valid;
  logic [ST_W-1:0]     out_status;
  logic [Q_W-1:0]      out_new_queue;
  logic [MSG_W-1:0]    out_msg_out;
  logic [FILL_W-1:0]   out_fill_after;

  mailbox_tracker tracker = new();
  int             beats   = 0;

  multi_queue_message_mailbox uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_queue_sel   (in_queue_sel),
    .in_byte_count  (in_byte_count),
    .in_depth_req   (in_depth_req),
    .in_msg_in      (in_msg_in),
    .in_may_wait    (in_may_wait),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_new_queue  (out_new_queue),
    .out_msg_out    (out_msg_out),
    .out_fill_after (out_fill_after)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        tracker.log_request(in_req_type, in_queue_sel, in_byte_count, in_depth_req,
                            in_msg_in, in_may_wait);
      if (out_valid)
        tracker.match_reply(out_status, out_new_queue, out_msg_out, out_fill_after);
    end
  end

  task automatic issue(input logic [REQ_W-1:0] rq, input logic [Q_W-1:0] qs,
                       input logic [NB_W-1:0] nb, input logic [DEP_W-1:0] dr,
                       input logic [MSG_W-1:0] pl, input logic mw);
    if (!(beats >= 250 && beats < 380) && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= rq;
    in_queue_sel  <= qs;
    in_byte_count <= nb;
    in_depth_req  <= dr;
    in_msg_in     <= pl;
    in_may_wait   <= mw;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats++;
  endtask

  function automatic logic [MSG_W-1:0] rand_msg();
    return {$urandom, $urandom};
  endfunction

  task automatic create_random();
    if ($urandom_range(3) != 0)
      issue(REQ_CREATE, Q_W'($urandom), NB_W'($urandom_range(0, MAX_MSG_BYTES)),
            $urandom_range(1) ? DEP_W'($urandom_range(1, 4))
                              : DEP_W'($urandom_range(1, MAX_DEPTH)),
            rand_msg(), 1'($urandom));
    else
      issue(REQ_CREATE, Q_W'($urandom), NB_W'($urandom), DEP_W'($urandom),
            rand_msg(), 1'($urandom));
  endtask

  task automatic burst_random();
    int               open_q[$];
    int               q;
    int               len;
    logic [REQ_W-1:0] dir;
    logic [NB_W-1:0]  nb;
    for (int i = 0; i < NUM_QUEUES; i++) if (tracker.q_open[i]) open_q.push_back(i);
    if (open_q.size() == 0) begin
      create_random();
      return;
    end
    q   = open_q[$urandom_range(open_q.size() - 1)];
    dir = $urandom_range(1) ? REQ_SEND : REQ_RECV;
    len = $urandom_range(1, int'(tracker.q_depth[q]) + 2);
    for (int k = 0; k < len; k++) begin
      nb = ($urandom_range(9) == 0) ? NB_W'($urandom) : tracker.q_msg_bytes[q];
      issue(dir, Q_W'(q), nb, DEP_W'($urandom), rand_msg(), 1'($urandom));
    end
  endtask

  initial begin
    int pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    issue(REQ_SEND,   4'd0,  4'd8, 5'd0,  '1, 1'b0);
    issue(REQ_RECV,   4'd15, 4'd8, 5'd0,  '1, 1'b1);
    issue(REQ_T3,     4'd5,  4'd0, 5'd0,  '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd4, 5'd0,  '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd4, 5'd17, '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd4, 5'd31, '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd9, 5'd4,  '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd8, 5'd1,  '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd0, 5'd16, '0, 1'b0);
    issue(REQ_CREATE, 4'd0,  4'd3, 5'd2,  '0, 1'b0);
    issue(REQ_SEND,   4'd0,  4'd8, 5'd0,  '1, 1'b0);
    issue(REQ_SEND,   4'd0,  4'd8, 5'd0,  '1, 1'b0);
    issue(REQ_SEND,   4'd0,  4'd8, 5'd0,  '1, 1'b1);
    issue(REQ_SEND,   4'd0,  4'd7, 5'd0,  '1, 1'b0);
    issue(REQ_T3,     4'd0,  4'd0, 5'd0,  '0, 1'b0);
    issue(REQ_RECV,   4'd0,  4'd8, 5'd0,  '0, 1'b0);
    issue(REQ_RECV,   4'd0,  4'd8, 5'd0,  '0, 1'b0);
    issue(REQ_RECV,   4'd0,  4'd8, 5'd0,  '0, 1'b1);
    issue(REQ_SEND,   4'd1,  4'd0, 5'd0,  '1, 1'b0);
    issue(REQ_RECV,   4'd1,  4'd0, 5'd0,  '0, 1'b0);
    issue(REQ_SEND,   4'd2,  4'd3, 5'd0,  rand_msg(), 1'b0);
    issue(REQ_SEND,   4'd2,  4'd3, 5'd0,  rand_msg(), 1'b0);
    issue(REQ_SEND,   4'd2,  4'd3, 5'd0,  rand_msg(), 1'b0);
    issue(REQ_RECV,   4'd2,  4'd3, 5'd0,  '0, 1'b0);
    issue(REQ_RECV,   4'd2,  4'd3, 5'd0,  '0, 1'b0);

    while (beats < 550) begin
      pick = $urandom_range(99);
      if (pick < 8)
        create_random();
      else if (pick < 18)
        issue(REQ_W'($urandom), Q_W'($urandom), NB_W'($urandom), DEP_W'($urandom),
              rand_msg(), 1'($urandom));
      else
        burst_random();
    end
    start <= 1'b0;

    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### multi_queue_message_mailbox.f
hw/rtl/mqmb_pkg.sv
hw/rtl/mqmb_ram.sv
hw/rtl/multi_queue_message_mailbox.sv
verif/mailbox_tracker_pkg.sv
verif/testbench.sv
